>>> rtl/launch_timer_speed_milestones_core_defines.svh
// assertion macros for the launch timer checker
`ifndef LAUNCH_TIMER_SPEED_MILESTONES_CORE_DEFINES_SVH
`define LAUNCH_TIMER_SPEED_MILESTONES_CORE_DEFINES_SVH

// property that is checked on every rising clock edge outside reset
`define LTSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication that is checked on every rising clock edge outside reset
`define LTSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/ltsm_pkg.sv
// shared types and constants of the launch timer
`timescale 1ns / 1ps

package ltsm_pkg;

	// run modes
	typedef enum logic [1:0] {
		MODE_READY    = 2'd0,
		MODE_RUNNING  = 2'd1,
		MODE_FINISHED = 2'd2
	} ltsm_mode_t;

	// field widths
	localparam int SPEED_W = 13;
	localparam int ACCEL_W = 15;
	localparam int PEAK_W  = 14;
	localparam int TS_W    = 48;
	localparam int TIME_W  = 32;

	// thresholds in 0.1 km/h, milli-g and microseconds
	localparam logic [SPEED_W-1:0] SPEED_WIN_LO   = 13'd15;
	localparam logic [SPEED_W-1:0] SPEED_WIN_HI   = 13'd150;
	localparam logic [SPEED_W-1:0] SPEED_ACC_MIN  = 13'd8;
	localparam logic [SPEED_W-1:0] SPEED_FALSE    = 13'd20;
	localparam logic [SPEED_W-1:0] SPEED_MARK_60  = 13'd600;
	localparam logic [SPEED_W-1:0] SPEED_MARK_100 = 13'd1000;
	localparam logic [SPEED_W-1:0] TARGET_RESET   = 13'd1000;
	localparam logic signed [ACCEL_W-1:0] ACCEL_LAUNCH = 15'sd250;
	localparam logic [TIME_W-1:0] FALSE_TIMEOUT   = 32'd2500000;

	// tdata widths, whole bytes
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 128;

	// one input item
	typedef struct packed {
		logic                      action;
		logic [SPEED_W-1:0]        speed;
		logic signed [ACCEL_W-1:0] accel;
		logic [TS_W-1:0]           timestamp_us;
	} ltsm_item_t;

	// timer state; all of it but start_time also forms a result item
	typedef struct packed {
		ltsm_mode_t          run_mode;
		logic [TS_W-1:0]     start_time;
		logic [TIME_W-1:0]   elapsed_time;
		logic [SPEED_W-1:0]  peak_speed;
		logic [PEAK_W-1:0]   peak_accel;
		logic [TIME_W-1:0]   mark_60;
		logic [TIME_W-1:0]   mark_100;
	} ltsm_state_t;

endpackage

>>> rtl/ltsm_step.sv
// next-state logic of the launch timer for one item
`timescale 1ns / 1ps

module ltsm_step (
	input  ltsm_pkg::ltsm_item_t                cur_item,
	input  ltsm_pkg::ltsm_state_t               cur_state,
	input  logic [ltsm_pkg::SPEED_W-1:0]        target_speed,
	output ltsm_pkg::ltsm_state_t               nxt_state
);

	logic [ltsm_pkg::ACCEL_W-1:0] mag_w;
	logic [ltsm_pkg::PEAK_W-1:0]  mag;
	logic [ltsm_pkg::PEAK_W-1:0]  pos_accel;
	logic [ltsm_pkg::PEAK_W-1:0]  pa;
	logic [ltsm_pkg::TS_W-1:0]    diff;
	logic [ltsm_pkg::TIME_W-1:0]  el;
	logic                         by_speed;
	logic                         by_accel;

	// acceleration magnitude, saturated to the peak width
	always_comb begin
		mag_w = cur_item.accel[ltsm_pkg::ACCEL_W-1] ? (~cur_item.accel + 15'd1)
			: cur_item.accel;
		mag = mag_w[ltsm_pkg::ACCEL_W-1] ? {ltsm_pkg::PEAK_W{1'b1}}
			: mag_w[ltsm_pkg::PEAK_W-1:0];
		pa = (mag > cur_state.peak_accel) ? mag : cur_state.peak_accel;
		pos_accel = (cur_item.accel > 15'sd0) ? cur_item.accel[ltsm_pkg::PEAK_W-1:0]
			: '0;
	end

	// launch detection and elapsed time
	always_comb begin
		by_speed = (cur_item.speed >= ltsm_pkg::SPEED_WIN_LO)
			&& (cur_item.speed < ltsm_pkg::SPEED_WIN_HI);
		by_accel = (cur_item.accel > ltsm_pkg::ACCEL_LAUNCH)
			&& (cur_item.speed >= ltsm_pkg::SPEED_ACC_MIN);
		diff = cur_item.timestamp_us - cur_state.start_time;
		el = (diff[ltsm_pkg::TS_W-1:ltsm_pkg::TIME_W] != '0) ? {ltsm_pkg::TIME_W{1'b1}}
			: diff[ltsm_pkg::TIME_W-1:0];
	end

	// state update
	always_comb begin
		nxt_state = cur_state;
		if (cur_item.action) begin
			nxt_state.run_mode     = ltsm_pkg::MODE_READY;
			nxt_state.elapsed_time = '0;
			nxt_state.peak_speed   = '0;
			nxt_state.peak_accel   = '0;
		end else begin
			nxt_state.peak_accel = pa;
			case (cur_state.run_mode)
				ltsm_pkg::MODE_READY: begin
					if (by_speed || by_accel) begin
						nxt_state.run_mode     = ltsm_pkg::MODE_RUNNING;
						nxt_state.start_time   = cur_item.timestamp_us;
						nxt_state.elapsed_time = '0;
						nxt_state.peak_speed   = cur_item.speed;
						nxt_state.mark_60      = '0;
						nxt_state.mark_100     = '0;
						nxt_state.peak_accel   = pos_accel;
					end
				end
				ltsm_pkg::MODE_RUNNING: begin
					if ((el > ltsm_pkg::FALSE_TIMEOUT)
						&& (cur_item.speed < ltsm_pkg::SPEED_FALSE)) begin
						// false launch
						nxt_state.run_mode     = ltsm_pkg::MODE_READY;
						nxt_state.elapsed_time = '0;
						nxt_state.peak_speed   = '0;
					end else begin
						nxt_state.elapsed_time = el;
						if (cur_item.speed > cur_state.peak_speed) begin
							nxt_state.peak_speed = cur_item.speed;
						end
						if ((cur_item.speed >= ltsm_pkg::SPEED_MARK_60)
							&& (cur_state.mark_60 == '0)) begin
							nxt_state.mark_60 = el;
						end
						if ((cur_item.speed >= ltsm_pkg::SPEED_MARK_100)
							&& (cur_state.mark_100 == '0)) begin
							nxt_state.mark_100 = el;
						end
						if (cur_item.speed >= target_speed) begin
							nxt_state.run_mode = ltsm_pkg::MODE_FINISHED;
						end
					end
				end
				default: begin
					// finished: only the acceleration peak moves
				end
			endcase
		end
	end

endmodule

>>> rtl/launch_timer_speed_milestones_core.sv
// top level of the launch timer with speed milestones
`timescale 1ns / 1ps

// Launch timer: times a vehicle run from launch and reports milestones.
// Input channel s_axis: one item per sample or reset press; tuser is the
// action bit (1 = reset press), tdata carries speed, accel and timestamp.
// Output channel m_axis: one result item per input item with the mode,
// elapsed time, peak speed, peak acceleration and the 60 / 100 km/h times.
// Configuration: cfg_we writes cfg_wdata into the target speed register;
// write it only while no item is in flight.
// Flow: an item taken into the input register passes through the next-state
// logic into the result register, where its result is valid on m_axis; it
// moves on only while the result register is free or being taken.
// Throughput: one item per cycle while the result register is free or taken;
// the state update, a subtract, a negate and compares, sits between the registers.
// Reset: arst_n clears the mode to ready, all run figures to zero and the
// target speed to 100 km/h; no result is pending after reset.
// Stall: while m_axis_tready is low the result holds; at most one more item is
// taken into the input register, then s_axis_tready drops until the
// result is taken.
module launch_timer_speed_milestones_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// speed[12:0], accel[27:13], timestamp_us[75:28], zero fill
	input  logic [ltsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// action[0]
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// mode_out[1:0], elapsed_us[33:2], max_speed_out[46:34],
	// peak_accel_out[60:47], time_to_60[92:61], time_to_100[124:93], zero fill
	output logic [ltsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [ltsm_pkg::SPEED_W-1:0]         cfg_wdata
);

	logic                           valid_s1;
	ltsm_pkg::ltsm_item_t           item_s1;
	ltsm_pkg::ltsm_state_t          state_q;
	ltsm_pkg::ltsm_state_t          nxt_state;
	logic [ltsm_pkg::SPEED_W-1:0]   target_q;
	logic                           out_valid_q;
	logic [ltsm_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                           adv;

	// pipeline moves when the result register is free or being taken
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// target speed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ltsm_pkg::TARGET_RESET;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.action       <= s_axis_tuser;
			item_s1.speed        <= s_axis_tdata[12:0];
			item_s1.accel        <= s_axis_tdata[27:13];
			item_s1.timestamp_us <= s_axis_tdata[75:28];
		end
	end

	// next-state logic
	ltsm_step u_step (
		.cur_item     (item_s1),
		.cur_state    (state_q),
		.target_speed (target_q),
		.nxt_state    (nxt_state)
	);

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{run_mode: ltsm_pkg::MODE_READY, default: '0};
		end else if (adv && valid_s1) begin
			state_q <= nxt_state;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_data_q <= {3'b000, nxt_state.mark_100, nxt_state.mark_60,
				nxt_state.peak_accel, nxt_state.peak_speed,
				nxt_state.elapsed_time, nxt_state.run_mode};
		end
	end

endmodule

>>> rtl/ltsm_checker.sv
// port-level checker of the launch timer and its bind
`timescale 1ns / 1ps
`include "launch_timer_speed_milestones_core_defines.svh"

module ltsm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [ltsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	// a stalled result holds its value
	`LTSM_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

	// input is only held off while a result waits on the receiver
	`LTSM_ASSERT_IMP(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

	// in ready mode the elapsed time and the peak speed are zero
	`LTSM_ASSERT_IMP(a_ready_clear, m_axis_tvalid && (m_axis_tdata[1:0] == ltsm_pkg::MODE_READY), (m_axis_tdata[33:2] == 32'd0) && (m_axis_tdata[46:34] == 13'd0), "ready result with run figures")

	// the mode code never takes its unused value
	`LTSM_ASSERT_IMP(a_mode_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "bad mode code in result")

endmodule

bind launch_timer_speed_milestones_core ltsm_checker u_ltsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
